// File: sv/lcdmt_pkg.sv
`timescale 1ns / 1ps

package lcdmt_pkg;

    // Request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Mode codes as seen in the status register
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    // Register offsets within the LCD window
    localparam logic [3:0] OFF_CONTROL = 4'd0;
    localparam logic [3:0] OFF_STATUS  = 4'd1;
    localparam logic [3:0] OFF_SCY     = 4'd2;
    localparam logic [3:0] OFF_SCX     = 4'd3;
    localparam logic [3:0] OFF_LINE    = 4'd4;
    localparam logic [3:0] OFF_LYC     = 4'd5;

    // Dot thresholds of each mode
    localparam int unsigned DOT_W = 10;
    localparam logic [DOT_W-1:0] DOTS_OAM    = 10'd80;
    localparam logic [DOT_W-1:0] DOTS_XFER   = 10'd172;
    localparam logic [DOT_W-1:0] DOTS_HBLANK = 10'd204;
    localparam logic [DOT_W-1:0] DOTS_LINE   = 10'd456;

    // Line limits
    localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
    localparam logic [7:0] LAST_LINE         = 8'd153;

endpackage

// File: sv/lcd_mode_timing_and_registers.sv
`timescale 1ns / 1ps

// Stages: input register, then result register; an accepted item moves from the input
// register into the result register, and its result is then offered on o_out_valid.
// Throughput: one item per cycle while i_out_ready does not stall the result side; the
// mode/line/dot state updates in the same cycle the item moves from the input register into the result register.
// Reset (i_rst_n low, synchronous): mode OAM search, line 0, dot 0, control/SCY/SCX/LYC 0,
// both pipeline stages empty.
module lcd_mode_timing_and_registers (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_req_type,
    input  logic [3:0] i_reg_offset,
    input  logic [7:0] i_wdata,
    input  logic [7:0] i_ticks,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_rdata,
    output logic [1:0] o_lcd_mode,
    output logic [7:0] o_current_line,
    output logic       o_line_done,
    output logic       o_frame_done
);
    import lcdmt_pkg::*;

    // Input stage
    logic       r_in_valid;
    logic [1:0] r_req;
    logic [3:0] r_off;
    logic [7:0] r_wdata;
    logic [7:0] r_ticks;

    // Controller state
    logic [1:0]       r_mode,  n_mode;
    logic [7:0]       r_line,  n_line;
    logic [DOT_W-1:0] r_dot,   n_dot;
    logic [5:0]       r_ctrl,  n_ctrl;
    logic [7:0]       r_scy,   n_scy;
    logic [7:0]       r_scx,   n_scx;
    logic [7:0]       r_lyc,   n_lyc;

    // Result stage
    logic       r_out_valid;
    logic [7:0] r_rdata, n_rdata;
    logic       r_ldone, n_ldone;
    logic       r_fdone, n_fdone;
    logic [1:0] r_res_mode;
    logic [7:0] r_res_line;

    logic             advance;
    logic [DOT_W-1:0] dot_sum;
    logic [7:0]       line_inc;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign dot_sum  = r_dot + {{(DOT_W-8){1'b0}}, r_ticks};
    assign line_inc = r_line + 8'd1;

    // Work out the next state and the result of the item in the input stage
    always_comb begin
        n_mode  = r_mode;
        n_line  = r_line;
        n_dot   = r_dot;
        n_ctrl  = r_ctrl;
        n_scy   = r_scy;
        n_scx   = r_scx;
        n_lyc   = r_lyc;
        n_rdata = 8'd0;
        n_ldone = 1'b0;
        n_fdone = 1'b0;
        if (r_req == REQ_TICK) begin
            n_dot = dot_sum;
            case (r_mode)
                MODE_XFER: begin
                    if (dot_sum >= DOTS_XFER) begin
                        n_dot   = '0;
                        n_mode  = MODE_HBLANK;
                        n_ldone = 1'b1;
                    end
                end
                MODE_OAM: begin
                    if (dot_sum >= DOTS_OAM) begin
                        n_dot  = '0;
                        n_mode = MODE_XFER;
                    end
                end
                MODE_VBLANK: begin
                    if (dot_sum >= DOTS_LINE) begin
                        n_dot  = '0;
                        n_line = line_inc;
                        if (line_inc > LAST_LINE) begin
                            n_line = 8'd0;
                            n_mode = MODE_OAM;
                        end
                    end
                end
                default: begin
                    if (dot_sum >= DOTS_HBLANK) begin
                        n_dot  = '0;
                        n_line = line_inc;
                        if (line_inc == FIRST_VBLANK_LINE) begin
                            n_mode  = MODE_VBLANK;
                            n_fdone = 1'b1;
                        end else begin
                            n_mode = MODE_OAM;
                        end
                    end
                end
            endcase
        end else if (r_req == REQ_READ) begin
            case (r_off)
                OFF_CONTROL: n_rdata = {r_ctrl[5], 2'b00, r_ctrl[4:0]};
                OFF_STATUS:  n_rdata = {5'd0, (r_line == r_lyc), r_mode};
                OFF_SCY:     n_rdata = r_scy;
                OFF_SCX:     n_rdata = r_scx;
                OFF_LINE:    n_rdata = r_line;
                OFF_LYC:     n_rdata = r_lyc;
                default:     n_rdata = 8'd0;
            endcase
        end else if (r_req == REQ_WRITE) begin
            case (r_off)
                OFF_CONTROL: n_ctrl = {r_wdata[7], r_wdata[4:0]};
                OFF_SCY:     n_scy  = r_wdata;
                OFF_SCX:     n_scx  = r_wdata;
                OFF_LYC:     n_lyc  = r_wdata;
                default:     n_ctrl = r_ctrl;
            endcase
        end
    end

    // Hold the input item until the result stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_req   <= i_req_type;
            r_off   <= i_reg_offset;
            r_wdata <= i_wdata;
            r_ticks <= i_ticks;
        end
    end

    // Advance state and load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_OAM;
            r_line      <= 8'd0;
            r_dot       <= '0;
            r_ctrl      <= 6'd0;
            r_scy       <= 8'd0;
            r_scx       <= 8'd0;
            r_lyc       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_mode      <= n_mode;
                r_line      <= n_line;
                r_dot       <= n_dot;
                r_ctrl      <= n_ctrl;
                r_scy       <= n_scy;
                r_scx       <= n_scx;
                r_lyc       <= n_lyc;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_rdata    <= n_rdata;
            r_ldone    <= n_ldone;
            r_fdone    <= n_fdone;
            r_res_mode <= n_mode;
            r_res_line <= n_line;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_rdata        = r_rdata;
    assign o_lcd_mode     = r_res_mode;
    assign o_current_line = r_res_line;
    assign o_line_done    = r_ldone;
    assign o_frame_done   = r_fdone;

endmodule

// File: dv/tb_lcd_mode_timing_and_registers.sv
`timescale 1ns / 1ps

module tb_lcd_mode_timing_and_registers;

    import lcdmt_pkg::*;

    // Request code that the block must treat as a no-op
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Offsets outside the implemented register map
    localparam logic [3:0] OFF_UNMAPPED_LO = 4'd6;
    localparam logic [3:0] OFF_UNMAPPED_HI = 4'd15;

    localparam int RANDOM_ITEMS_PER_PHASE = 310;
    localparam int DRAIN_CYCLES           = 4;

    typedef struct packed {
        logic [7:0] rdata;
        logic [1:0] lcd_mode;
        logic [7:0] current_line;
        logic       line_done;
        logic       frame_done;
    } lcd_result_t;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [1:0] i_req_type     = REQ_TICK;
    logic [3:0] i_reg_offset   = OFF_CONTROL;
    logic [7:0] i_wdata        = 8'd0;
    logic [7:0] i_ticks        = 8'd0;
    logic       i_out_ready    = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_rdata;
    logic [1:0] o_lcd_mode;
    logic [7:0] o_current_line;
    logic       o_line_done;
    logic       o_frame_done;

    // Shadow copy of the LCD timing state and registers
    logic [1:0]       lcd_mode_q;
    logic [7:0]       lcd_line_q;
    logic [DOT_W-1:0] lcd_dot_q;
    logic [5:0]       lcd_ctrl_q;
    logic [7:0]       lcd_scy_q;
    logic [7:0]       lcd_scx_q;
    logic [7:0]       lcd_lyc_q;

    lcd_result_t pending_lcd_results[$];
    int          error_count     = 0;
    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;

    lcd_mode_timing_and_registers i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_reg_offset   (i_reg_offset),
        .i_wdata        (i_wdata),
        .i_ticks        (i_ticks),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_rdata        (o_rdata),
        .o_lcd_mode     (o_lcd_mode),
        .o_current_line (o_current_line),
        .o_line_done    (o_line_done),
        .o_frame_done   (o_frame_done)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result side at the rate of the current phase
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [7:0] lcd_reg_value(input logic [3:0] off);
        case (off)
            OFF_CONTROL: return {lcd_ctrl_q[5], 2'b00, lcd_ctrl_q[4:0]};
            OFF_STATUS:  return {5'd0, (lcd_line_q == lcd_lyc_q), lcd_mode_q};
            OFF_SCY:     return lcd_scy_q;
            OFF_SCX:     return lcd_scx_q;
            OFF_LINE:    return lcd_line_q;
            OFF_LYC:     return lcd_lyc_q;
            default:     return 8'd0;
        endcase
    endfunction

    // Advance the shadow state by one item and queue the result it produces
    task automatic predict_lcd_step(input logic [1:0] req, input logic [3:0] off,
                                    input logic [7:0] wd, input logic [7:0] tk);
        lcd_result_t res;
        res = '0;
        case (req)
            REQ_TICK: begin
                lcd_dot_q = lcd_dot_q + DOT_W'(tk);
                case (lcd_mode_q)
                    MODE_XFER: begin
                        if (lcd_dot_q >= DOTS_XFER) begin
                            lcd_dot_q     = '0;
                            lcd_mode_q    = MODE_HBLANK;
                            res.line_done = 1'b1;
                        end
                    end
                    MODE_OAM: begin
                        if (lcd_dot_q >= DOTS_OAM) begin
                            lcd_dot_q  = '0;
                            lcd_mode_q = MODE_XFER;
                        end
                    end
                    MODE_VBLANK: begin
                        if (lcd_dot_q >= DOTS_LINE) begin
                            lcd_dot_q  = '0;
                            lcd_line_q = lcd_line_q + 8'd1;
                            // wrap to the top of the next frame
                            if (lcd_line_q > LAST_LINE) begin
                                lcd_line_q = 8'd0;
                                lcd_mode_q = MODE_OAM;
                            end
                        end
                    end
                    default: begin
                        if (lcd_dot_q >= DOTS_HBLANK) begin
                            lcd_dot_q  = '0;
                            lcd_line_q = lcd_line_q + 8'd1;
                            if (lcd_line_q == FIRST_VBLANK_LINE) begin
                                lcd_mode_q     = MODE_VBLANK;
                                res.frame_done = 1'b1;
                            end else begin
                                lcd_mode_q = MODE_OAM;
                            end
                        end
                    end
                endcase
            end
            REQ_READ: begin
                res.rdata = lcd_reg_value(off);
            end
            REQ_WRITE: begin
                case (off)
                    OFF_CONTROL: lcd_ctrl_q = {wd[7], wd[4:0]};
                    OFF_SCY:     lcd_scy_q  = wd;
                    OFF_SCX:     lcd_scx_q  = wd;
                    OFF_LYC:     lcd_lyc_q  = wd;
                    default:     ;
                endcase
            end
            default: ;
        endcase
        res.lcd_mode     = lcd_mode_q;
        res.current_line = lcd_line_q;
        pending_lcd_results.push_back(res);
    endtask

    // Drive one item, holding it until the block takes it
    task automatic send_item(input logic [1:0] req, input logic [3:0] off,
                             input logic [7:0] wd, input logic [7:0] tk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_reg_offset <= off;
        i_wdata      <= wd;
        i_ticks      <= tk;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        predict_lcd_step(req, off, wd, tk);
    endtask

    // Drop valid and hold until every queued result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_lcd_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_register_access();
        send_item(REQ_READ,  OFF_STATUS,      8'hA5, 8'hFF);
        send_item(REQ_WRITE, OFF_CONTROL,     8'hFF, 8'h00);
        send_item(REQ_READ,  OFF_CONTROL,     8'h00, 8'h00);
        send_item(REQ_WRITE, OFF_CONTROL,     8'h60, 8'hFF);
        send_item(REQ_READ,  OFF_CONTROL,     8'hFF, 8'hFF);
        // read-only registers ignore writes
        send_item(REQ_WRITE, OFF_STATUS,      8'hFF, 8'h00);
        send_item(REQ_WRITE, OFF_LINE,        8'hFF, 8'h00);
        send_item(REQ_READ,  OFF_STATUS,      8'h00, 8'h00);
        send_item(REQ_READ,  OFF_LINE,        8'h00, 8'h00);
        send_item(REQ_WRITE, OFF_SCY,         8'hFF, 8'h00);
        send_item(REQ_WRITE, OFF_SCX,         8'h5A, 8'h00);
        send_item(REQ_READ,  OFF_SCY,         8'h00, 8'h00);
        send_item(REQ_READ,  OFF_SCX,         8'h00, 8'h00);
        send_item(REQ_WRITE, OFF_LYC,         8'h01, 8'h00);
        send_item(REQ_READ,  OFF_STATUS,      8'h00, 8'h00);
        send_item(REQ_READ,  OFF_LYC,         8'h00, 8'h00);
        // unmapped offsets read zero and drop writes
        send_item(REQ_WRITE, OFF_UNMAPPED_HI, 8'hFF, 8'hFF);
        send_item(REQ_READ,  OFF_UNMAPPED_HI, 8'hFF, 8'hFF);
        send_item(REQ_READ,  OFF_UNMAPPED_LO, 8'h00, 8'h00);
        drain_results();
    endtask

    task automatic test_mode_timing();
        send_item(REQ_UNUSED, OFF_UNMAPPED_HI, 8'hFF, 8'hFF);
        send_item(REQ_TICK,   OFF_CONTROL,     8'h00, 8'd0);
        send_item(REQ_TICK,   OFF_CONTROL,     8'h00, 8'd79);
        send_item(REQ_TICK,   OFF_CONTROL,     8'h00, 8'd1);
        send_item(REQ_TICK,   OFF_CONTROL,     8'h00, 8'd171);
        send_item(REQ_TICK,   OFF_CONTROL,     8'h00, 8'd255);
        send_item(REQ_TICK,   OFF_CONTROL,     8'h00, 8'd255);
        drain_results();
    endtask

    // Mostly large ticks so frames complete, mixed with register traffic
    task automatic run_random_items(input int count);
        logic [1:0] req;
        logic [3:0] off;
        logic [7:0] wd;
        logic [7:0] tk;
        int         pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            off  = $urandom_range(0, 99) < 80 ? 4'($urandom_range(0, 5))
                                              : 4'($urandom_range(0, 15));
            wd   = 8'($urandom_range(0, 255));
            tk   = $urandom_range(0, 1) ? 8'($urandom_range(170, 255))
                                        : 8'($urandom_range(0, 255));
            if (pick < 62) begin
                req = REQ_TICK;
            end else if (pick < 77) begin
                req = REQ_READ;
            end else if (pick < 95) begin
                req = REQ_WRITE;
                // aim some compare values at the current line
                if (off == OFF_LYC && $urandom_range(0, 1) == 1) begin
                    wd = lcd_line_q;
                end
            end else begin
                req = REQ_UNUSED;
            end
            send_item(req, off, wd, tk);
        end
        drain_results();
    endtask

    task automatic test_random_streaming();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_items(RANDOM_ITEMS_PER_PHASE);
    endtask

    task automatic test_random_sender_gaps();
        send_idle_pct  = 71;
        recv_stall_pct = 0;
        run_random_items(RANDOM_ITEMS_PER_PHASE);
    endtask

    task automatic test_random_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 71;
        run_random_items(RANDOM_ITEMS_PER_PHASE);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        run_random_items(RANDOM_ITEMS_PER_PHASE);
    endtask

    // Compare each returned item with the oldest queued result
    always @(posedge i_clk) begin
        lcd_result_t exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_lcd_results.size() == 0) begin
                $error("unexpected result: rdata %0d mode %0d line %0d",
                       o_rdata, o_lcd_mode, o_current_line);
                error_count++;
            end else begin
                exp_res = pending_lcd_results.pop_front();
                if (o_rdata !== exp_res.rdata) begin
                    $error("rdata: expected %0d, got %0d", exp_res.rdata, o_rdata);
                    error_count++;
                end
                if (o_lcd_mode !== exp_res.lcd_mode) begin
                    $error("lcd_mode: expected %0d, got %0d", exp_res.lcd_mode, o_lcd_mode);
                    error_count++;
                end
                if (o_current_line !== exp_res.current_line) begin
                    $error("current_line: expected %0d, got %0d",
                           exp_res.current_line, o_current_line);
                    error_count++;
                end
                if (o_line_done !== exp_res.line_done) begin
                    $error("line_done: expected %0d, got %0d", exp_res.line_done, o_line_done);
                    error_count++;
                end
                if (o_frame_done !== exp_res.frame_done) begin
                    $error("frame_done: expected %0d, got %0d",
                           exp_res.frame_done, o_frame_done);
                    error_count++;
                end
            end
        end
    end

    initial begin
        lcd_mode_q = MODE_OAM;
        lcd_line_q = 8'd0;
        lcd_dot_q  = '0;
        lcd_ctrl_q = 6'd0;
        lcd_scy_q  = 8'd0;
        lcd_scx_q  = 8'd0;
        lcd_lyc_q  = 8'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_mode_timing();
        test_random_streaming();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_both_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Bound the run in case the handshake hangs
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: lcd_mode_timing_and_registers.f
sv/lcdmt_pkg.sv
sv/lcd_mode_timing_and_registers.sv
dv/tb_lcd_mode_timing_and_registers.sv
